### rtl/isw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isw_pkg
// shared constants, types and key normalisation for the word sorter
// ----------------------------------------------------------------------------
package isw_pkg;

  localparam int MAX_WORDS  = 64;
  localparam int WORD_CHARS = 8;
  localparam int CHAR_W     = 8;
  localparam int KEY_CHARS  = 8;
  localparam int KEY_W      = KEY_CHARS * CHAR_W;

  typedef logic [KEY_W-1:0] key_t;

  // broadcast from the control to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
    key_t key;
  } isw_cmd_t;

  // keep the first WORD_CHARS characters, clear everything after a zero byte
  function automatic key_t isw_normalise(input key_t raw);
    key_t              kept;
    logic              alive;
    logic [CHAR_W-1:0] ch;
    kept  = '0;
    alive = 1'b1;
    for (int c = 0; c < KEY_CHARS; c++) begin
      ch    = raw[CHAR_W*(KEY_CHARS-1-c) +: CHAR_W];
      alive = alive && (c < WORD_CHARS) && (ch != '0);
      if (alive) begin
        kept[CHAR_W*(KEY_CHARS-1-c) +: CHAR_W] = ch;
      end
    end
    return kept;
  endfunction

endpackage
`default_nettype wire

### rtl/isw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isw_cell
// one slot of the sorted chain: holds a key, takes the new key or its lower
// neighbour's key on insert, and its upper neighbour's key on pop
// ----------------------------------------------------------------------------
module isw_cell
  import isw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire isw_cmd_t cmd,
  input  wire logic     prev_valid,
  input  wire logic     prev_gt,
  input  wire key_t     prev_key,
  input  wire logic     next_valid,
  input  wire key_t     next_key,
  output logic          valid,
  output logic          gt,
  output key_t          key
);

  logic valid_r, valid_nxt;
  key_t key_r, key_nxt;

  assign gt = valid_r && (cmd.key < key_r);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (cmd.ins) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
      end else if (gt || (!valid_r && prev_valid)) begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
      end
    end else if (cmd.pop) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;

endmodule
`default_nettype wire

### rtl/insertion_sort_words.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_words
// sorts a run of words into ascending order in a chain of cells and streams
// the run out, lowest first, after the beat marked last
//
//   channel | tdata          | tlast     | tuser
//   in_     | word_key[63:0] | last_word | -
//   out_    | sorted_key     | last_out  | overflow
//
// a word is inserted in the beat's cycle, so the next beat can follow without a wait.
// after the last beat the run drains one word per cycle from the head cell,
// the chain shifting down; input is held off until the final word is taken.
// a word arriving with all cells full is dropped and flags the run.
// reset empties the chain; out_tready stalls hold the chain as it stands.
// ----------------------------------------------------------------------------
module insertion_sort_words
  import isw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [KEY_W-1:0] in_tdata,   // word_key
  input  wire logic             in_tlast,   // last_word
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [KEY_W-1:0]      out_tdata,  // sorted_key
  output logic                  out_tlast,  // last_out
  output logic                  out_tuser   // overflow
);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t   state_r;
  logic     dropped_r;
  isw_cmd_t cmd;
  logic     in_acc, out_acc, full;

  logic [MAX_WORDS-1:0] cell_valid;
  logic [MAX_WORDS-1:0] cell_gt;
  key_t                 cell_key [MAX_WORDS];

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign full      = cell_valid[MAX_WORDS-1];

  assign cmd = {in_acc && !full, out_acc, isw_normalise(in_tdata)};

  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    logic prev_valid, prev_gt, next_valid;
    key_t prev_key, next_key;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
      assign prev_key   = '0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
      assign prev_key   = cell_key[i-1];
    end
    if (i == MAX_WORDS - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
    end
    isw_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (prev_valid),
      .prev_gt    (prev_gt),
      .prev_key   (prev_key),
      .next_valid (next_valid),
      .next_key   (next_key),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .key        (cell_key[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped_r <= 1'b1;
            end
            if (in_tlast) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc && out_tlast) begin
            state_r   <= ST_LOAD;
            dropped_r <= 1'b0;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_tdata  = cell_key[0];
  assign out_tlast  = !cell_valid[1];
  assign out_tuser  = dropped_r;

endmodule
`default_nettype wire

### rtl/isw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isw_checker
// port-level checks on the word sorter, bound to the top level
// ----------------------------------------------------------------------------
module isw_checker
  import isw_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             in_tlast,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [KEY_W-1:0] out_tdata,
  input wire logic             out_tlast,
  input wire logic             out_tuser
);

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while draining");

  // the last input beat starts the drain
  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("no output after last beat");

  // the final output beat ends the drain
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("drain did not end after last beat");

  // overflow holds steady across the output beats of a run
  a_flag_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tuser == $past(out_tuser)))
    else $error("overflow changed within a run");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output beat changed");

endmodule

bind insertion_sort_words isw_checker u_isw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
